>>> design/rtcv_pkg.sv
// shared types, constants and conversion functions for the rtc time converter
package rtcv_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // register index taken from the word address bit
    localparam logic REG_BINARY_MODE = 1'b0;
    localparam logic REG_HOUR24_MODE = 1'b1;

    localparam logic FUNC_DECODE = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 72;

    localparam logic [7:0] SEC_LIMIT  = 8'd60;
    localparam logic [7:0] MIN_LIMIT  = 8'd60;
    localparam logic [7:0] HOUR_LIMIT = 8'd24;
    localparam logic [7:0] HOUR_NOON  = 8'd12;
    localparam logic [7:0] MONTH_MAX  = 8'd12;
    localparam logic [7:0] YEAR_LAST  = 8'd99;

    typedef struct packed {
        logic        func;
        logic [7:0]  second_val;
        logic [7:0]  minute_val;
        logic [7:0]  hour_val;
        logic [7:0]  day_val;
        logic [7:0]  month_val;
        logic [13:0] year_val;
        logic [7:0]  century_val;
    } rtcv_item_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  second_out;
        logic [7:0]  minute_out;
        logic [7:0]  hour_out;
        logic [7:0]  day_out;
        logic [7:0]  month_out;
        logic [15:0] year_out;
        logic [7:0]  century_out;
        logic        century_write;
    } rtcv_result_t;

    typedef struct packed {
        logic binary_mode;
        logic hour24_mode;
    } rtcv_cfg_t;

    // low nibble plus ten times high nibble, no digit check
    function automatic logic [7:0] bcd_dec(input logic [7:0] x);
        logic [7:0] hi8;
        logic [7:0] hi2;
        hi8 = {1'b0, x[7:4], 3'b000};
        hi2 = {3'b000, x[7:4], 1'b0};
        return {4'd0, x[3:0]} + hi8 + hi2;
    endfunction

    // tens in the high nibble, ones in the low, wrapped to a byte
    function automatic logic [7:0] bcd_enc(input logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        prod = 16'(v) * 16'd205;
        q    = {3'd0, prod[15:11]};
        r    = v - 8'(q * 8'd10);
        return {q[3:0], 4'b0000} + r;
    endfunction

    function automatic logic [7:0] days_in_month(input logic [3:0] mon, input logic leap);
        logic [7:0] d;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 8'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 8'd30;
            4'd2:                                       d = leap ? 8'd29 : 8'd28;
            default:                                    d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

>>> design/rtcv_convert.sv
// decode and validate/encode datapath for one request, with the next pending flag
module rtcv_convert (
    input  rtcv_pkg::rtcv_item_t   item,
    input  rtcv_pkg::rtcv_cfg_t    cfg,
    input  logic                   pending,
    output rtcv_pkg::rtcv_result_t result,
    output logic                   pending_next
);
    import rtcv_pkg::*;

    // decode path
    logic [7:0]  d_sec, d_min, d_hr_b, d_hr7, d_hr, d_day, d_mon, d_yr, d_cen, d_cen_n;
    logic        d_pm, d_roll;
    logic [15:0] d_year;
    logic [7:0]  d_cen_out;

    // encode path
    logic [26:0] e_prod;
    logic [7:0]  e_cen;
    logic [13:0] e_rem;
    logic [7:0]  e_y2;
    logic        e_leap, e_bad;
    logic [7:0]  e_hr, e_pm;
    logic        e_pend;

    always_comb begin
        d_pm   = item.hour_val[7];
        d_sec  = cfg.binary_mode ? item.second_val : bcd_dec(item.second_val);
        d_min  = cfg.binary_mode ? item.minute_val : bcd_dec(item.minute_val);
        d_day  = cfg.binary_mode ? item.day_val : bcd_dec(item.day_val);
        d_mon  = cfg.binary_mode ? item.month_val : bcd_dec(item.month_val);
        d_yr   = cfg.binary_mode ? item.year_val[7:0] : bcd_dec(item.year_val[7:0]);
        d_cen  = cfg.binary_mode ? item.century_val : bcd_dec(item.century_val);
        d_hr_b = cfg.binary_mode ? item.hour_val
                                 : (bcd_dec({1'b0, item.hour_val[6:0]}) | {d_pm, 7'd0});
        d_hr7  = {1'b0, d_hr_b[6:0]};
        if (cfg.hour24_mode) begin
            d_hr = d_hr_b;
        end else if (d_pm) begin
            d_hr = (d_hr7 == HOUR_NOON) ? HOUR_NOON : d_hr7 + HOUR_NOON;
        end else begin
            d_hr = (d_hr7 == HOUR_NOON) ? 8'd0 : d_hr7;
        end
        d_roll    = pending && (d_yr == 8'd0);
        d_cen_n   = d_roll ? d_cen + 8'd1 : d_cen;
        d_year    = 16'(d_yr) + 16'(d_cen_n) * 16'd100;
        d_cen_out = d_roll ? (cfg.binary_mode ? d_cen_n : bcd_enc(d_cen_n)) : 8'd0;
    end

    always_comb begin
        // divide by 100 via reciprocal, exact over 14 bits
        e_prod = 27'(item.year_val) * 27'd5243;
        e_cen  = e_prod[26:19];
        e_rem  = item.year_val - 14'(e_cen) * 14'd100;
        e_y2   = e_rem[7:0];
        e_leap = (item.year_val[1:0] == 2'b00) && ((e_y2 != 8'd0) || (e_cen[1:0] == 2'b00));
        e_bad  = (item.second_val >= SEC_LIMIT) || (item.minute_val >= MIN_LIMIT) ||
                 (item.hour_val >= HOUR_LIMIT) || (item.month_val == 8'd0) ||
                 (item.month_val > MONTH_MAX) || (item.day_val == 8'd0) ||
                 (item.day_val > days_in_month(item.month_val[3:0], e_leap));
        e_pend = !pending && (e_y2 == YEAR_LAST);
        e_pm   = 8'd0;
        e_hr   = item.hour_val;
        if (!cfg.hour24_mode) begin
            if (item.hour_val >= HOUR_NOON) begin
                e_pm = 8'h80;
            end
            if (item.hour_val > HOUR_NOON) begin
                e_hr = item.hour_val - HOUR_NOON;
            end else if (item.hour_val == 8'd0) begin
                e_hr = HOUR_NOON;
            end
        end
    end

    always_comb begin
        result       = '0;
        pending_next = pending;
        if (item.func == FUNC_DECODE) begin
            result.status        = STATUS_OK;
            result.second_out    = d_sec;
            result.minute_out    = d_min;
            result.hour_out      = d_hr;
            result.day_out       = d_day;
            result.month_out     = d_mon;
            result.year_out      = d_year;
            result.century_out   = d_cen_out;
            result.century_write = d_roll;
            if (!pending && (d_yr == YEAR_LAST)) begin
                pending_next = 1'b1;
            end else if (d_roll) begin
                pending_next = 1'b0;
            end
        end else if (e_bad) begin
            result.status = STATUS_INVALID;
        end else begin
            pending_next         = e_pend;
            result.status        = STATUS_OK;
            result.second_out    = cfg.binary_mode ? item.second_val : bcd_enc(item.second_val);
            result.minute_out    = cfg.binary_mode ? item.minute_val : bcd_enc(item.minute_val);
            result.hour_out      = (cfg.binary_mode ? e_hr : bcd_enc(e_hr)) | e_pm;
            result.day_out       = cfg.binary_mode ? item.day_val : bcd_enc(item.day_val);
            result.month_out     = cfg.binary_mode ? item.month_val : bcd_enc(item.month_val);
            result.year_out      = {8'd0, cfg.binary_mode ? e_y2 : bcd_enc(e_y2)};
            result.century_out   = cfg.binary_mode ? e_cen : bcd_enc(e_cen);
            result.century_write = 1'b1;
        end
    end

endmodule

>>> design/rtc_time_convert_validate_top.sv
// rtc time converter: the input register loads at the request accept, and the result register,
// which drives m_tvalid, loads from it once the output stage is empty or m_tready is high;
// throughput one request per cycle when m_tready stays high.
// the century pending flag is updated as a request moves into the result register,
// so back-to-back requests see it in order.
// reset (aresetn low, synchronous) empties both stages, clears the pending flag and
// sets binary_mode to 0 and hour24_mode to 1
module rtc_time_convert_validate_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // second[7:0] minute[15:8] hour[23:16] day[31:24] month[39:32] year[53:40]
    // century[61:54], zero [63:62]
    input  logic [rtcv_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // second[7:0] minute[15:8] hour[23:16] day[31:24] month[39:32] year[55:40]
    // century[63:56] century_write[64], zero [71:65]
    output logic [rtcv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[0]
    output logic [0:0]                          m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtcv_pkg::ADDR_W-1:0]         paddr,
    input  logic [rtcv_pkg::DATA_W-1:0]         pwdata,
    output logic [rtcv_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import rtcv_pkg::*;

    logic         in_valid_reg, in_valid_next;
    rtcv_item_t   item_reg, item_next;
    logic         out_valid_reg, out_valid_next;
    rtcv_result_t result_reg, result_next;
    logic         pending_reg, pending_next;
    rtcv_cfg_t    cfg_reg, cfg_next;

    rtcv_result_t conv_result;
    logic         conv_pending;
    logic         advance, s_fire, cfg_wr;

    rtcv_convert u_convert (
        .item         (item_reg),
        .cfg          (cfg_reg),
        .pending      (pending_reg),
        .result       (conv_result),
        .pending_next (conv_pending)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        item_next.func        = s_tuser[0];
        item_next.second_val  = s_tdata[7:0];
        item_next.minute_val  = s_tdata[15:8];
        item_next.hour_val    = s_tdata[23:16];
        item_next.day_val     = s_tdata[31:24];
        item_next.month_val   = s_tdata[39:32];
        item_next.year_val    = s_tdata[53:40];
        item_next.century_val = s_tdata[61:54];

        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        result_next    = advance ? conv_result : result_reg;
        pending_next   = advance ? conv_pending : pending_reg;

        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_BINARY_MODE: cfg_next.binary_mode = pwdata[0];
                REG_HOUR24_MODE: cfg_next.hour24_mode = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            cfg_reg       <= '{binary_mode: 1'b0, hour24_mode: 1'b1};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= item_next;
        end
        result_reg <= result_next;
    end

    always_comb begin
        unique case (paddr[2])
            REG_BINARY_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.binary_mode};
            REG_HOUR24_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.hour24_mode};
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = {7'd0, result_reg.century_write, result_reg.century_out,
                       result_reg.year_out, result_reg.month_out, result_reg.day_out,
                       result_reg.hour_out, result_reg.minute_out, result_reg.second_out};

    // an invalid encode carries nothing but its status
    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.status |->
            !result_reg.century_write && result_reg.year_out == 16'd0 &&
            result_reg.hour_out == 8'd0 && result_reg.century_out == 8'd0)
        else $error("invalid result carries payload");

    // an invalid encode leaves the pending flag alone
    a_invalid_keeps_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && conv_result.status |=> pending_reg == $past(pending_reg))
        else $error("pending flag changed on invalid request");

    // a decode rollover write-back always clears the pending flag
    a_roll_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.func == FUNC_DECODE && conv_result.century_write |=> !pending_reg)
        else $error("pending flag survived century rollover");

    // an empty input stage never stalls the slave side
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // result register loads only when the input stage holds a request
    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg ##1 out_valid_reg |-> $past(in_valid_reg))
        else $error("result appeared without a request");

endmodule
